>>> rtl/trial_division_prime_counter_unit_defines.svh
// assertion macros shared by the checker
`ifndef TRIAL_DIVISION_PRIME_COUNTER_UNIT_DEFINES_SVH
`define TRIAL_DIVISION_PRIME_COUNTER_UNIT_DEFINES_SVH

// same-cycle implication
`define TDPC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TDPC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tdpc_pkg.sv
package tdpc_pkg;
	localparam int NUMBER_WIDTH_DEF = 16;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int OUT_COUNT_W      = 32;
	localparam int OUT_DATA_W       = 2 * OUT_COUNT_W;
	localparam int EXT_W            = 64;
endpackage

>>> rtl/trial_division_prime_counter_unit.sv
// trial division prime counter
// slave side: one signed number per beat on s_tdata (low NUMBER_WIDTH bits,
// two's complement); s_tready is high only while no number is in work.
// master side: one result beat per number; m_tuser holds the prime flag,
// m_tdata the saturating count of primes and of numbers seen since reset.
// a number below 2 goes straight from idle to the done state, with no division.
// otherwise each trial divisor d gets a check state that compares d*d with
// the number, then NUMBER_WIDTH steps of a bit-serial remainder unit that
// shifts the number in msb first. a prime n is tried with every divisor from
// 2 to floor(sqrt(n)); a composite stops at its smallest factor.
// the result sits in an output register, so a new number is taken while the
// previous result waits; a stalled receiver holds the result and, once the
// next number is finished, the block waits with s_tready low.
// reset (arst_n low) clears both counters and drops all valid beats.
module trial_division_prime_counter_unit #(
	parameter int NUMBER_WIDTH = tdpc_pkg::NUMBER_WIDTH_DEF,
	parameter int COUNT_WIDTH  = tdpc_pkg::COUNT_WIDTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [((NUMBER_WIDTH+7)/8)*8-1:0]     s_tdata,  // number
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [tdpc_pkg::OUT_DATA_W-1:0]       m_tdata,  // items_done (upper half), primes_found (lower half)
	output logic [0:0]                            m_tuser   // prime_flag
);
	localparam int CNT_W = $clog2(NUMBER_WIDTH);

	typedef enum logic [1:0] {ST_IDLE, ST_CHECK, ST_DIV, ST_DONE} state_t;

	state_t                  state_q;
	logic [NUMBER_WIDTH-1:0] v_q;
	logic [NUMBER_WIDTH-1:0] d_q;
	logic [NUMBER_WIDTH:0]   sq_q;
	logic [NUMBER_WIDTH-1:0] rem_q;
	logic [NUMBER_WIDTH-1:0] sh_q;
	logic [CNT_W-1:0]        cnt_q;
	logic                    flag_q;
	logic [COUNT_WIDTH-1:0]  prime_total_q;
	logic [COUNT_WIDTH-1:0]  proc_total_q;
	logic                    m_tvalid_q;
	logic [tdpc_pkg::OUT_DATA_W-1:0] m_tdata_q;
	logic                    m_tuser_q;

	logic [NUMBER_WIDTH-1:0] num;
	logic [NUMBER_WIDTH:0]   trial;
	logic                    trial_ge;
	logic [NUMBER_WIDTH-1:0] rem_nxt;
	logic [COUNT_WIDTH-1:0]  prime_nxt;
	logic [COUNT_WIDTH-1:0]  proc_nxt;
	logic [tdpc_pkg::EXT_W-1:0] prime_ext;
	logic [tdpc_pkg::EXT_W-1:0] proc_ext;
	logic                    out_free;

	assign num      = s_tdata[NUMBER_WIDTH-1:0];
	assign trial    = {rem_q, sh_q[NUMBER_WIDTH-1]};
	assign trial_ge = trial >= {1'b0, d_q};
	assign rem_nxt  = trial_ge ? NUMBER_WIDTH'(trial - {1'b0, d_q}) : trial[NUMBER_WIDTH-1:0];

	assign prime_nxt = (flag_q && (prime_total_q != '1)) ?
		prime_total_q + COUNT_WIDTH'(1) : prime_total_q;
	assign proc_nxt  = (proc_total_q != '1) ? proc_total_q + COUNT_WIDTH'(1) : proc_total_q;
	assign prime_ext = tdpc_pkg::EXT_W'(prime_nxt);
	assign proc_ext  = tdpc_pkg::EXT_W'(proc_nxt);
	assign out_free  = !m_tvalid_q || m_tready;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			v_q           <= '0;
			d_q           <= '0;
			sq_q          <= '0;
			rem_q         <= '0;
			sh_q          <= '0;
			cnt_q         <= '0;
			flag_q        <= 1'b0;
			prime_total_q <= '0;
			proc_total_q  <= '0;
			m_tvalid_q    <= 1'b0;
			m_tdata_q     <= '0;
			m_tuser_q     <= 1'b0;
		end else begin
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						v_q    <= num;
						d_q    <= NUMBER_WIDTH'(2);
						sq_q   <= (NUMBER_WIDTH + 1)'(4);
						flag_q <= 1'b0;
						// negative, zero and one are not prime
						if (num[NUMBER_WIDTH-1] || (num < NUMBER_WIDTH'(2))) begin
							state_q <= ST_DONE;
						end else begin
							state_q <= ST_CHECK;
						end
					end
				end
				ST_CHECK: begin
					if (sq_q > {1'b0, v_q}) begin
						flag_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						rem_q   <= '0;
						sh_q    <= v_q;
						cnt_q   <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q <= rem_nxt;
					sh_q  <= sh_q << 1;
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUMBER_WIDTH - 1)) begin
						if (rem_nxt == '0) begin
							flag_q  <= 1'b0;
							state_q <= ST_DONE;
						end else begin
							// (d+1)^2 = d^2 + 2d + 1
							sq_q    <= sq_q + {d_q, 1'b1};
							d_q     <= d_q + NUMBER_WIDTH'(1);
							state_q <= ST_CHECK;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						prime_total_q <= prime_nxt;
						proc_total_q  <= proc_nxt;
						m_tvalid_q    <= 1'b1;
						m_tuser_q     <= flag_q;
						m_tdata_q     <= {proc_ext[tdpc_pkg::OUT_COUNT_W-1:0],
						                  prime_ext[tdpc_pkg::OUT_COUNT_W-1:0]};
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end
endmodule

>>> rtl/tdpc_checker.sv
`include "trial_division_prime_counter_unit_defines.svh"

module tdpc_checker #(
	parameter int COUNT_WIDTH = tdpc_pkg::COUNT_WIDTH_DEF
) (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [tdpc_pkg::OUT_DATA_W-1:0]     m_tdata,
	input logic [0:0]                          m_tuser
);
	localparam bit NO_WRAP = (COUNT_WIDTH <= tdpc_pkg::OUT_COUNT_W);

	// stalled result beat holds
	`TDPC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed under stall")

	// one number in work at a time
	`TDPC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken while busy")

	// every result counts at least its own number
	`TDPC_ASSERT_NOW(a_items_nonzero, m_tvalid && NO_WRAP, m_tdata[tdpc_pkg::OUT_DATA_W-1:tdpc_pkg::OUT_COUNT_W] != '0, "items_done is zero")

	// a prime result has been counted
	`TDPC_ASSERT_NOW(a_prime_counted, m_tvalid && m_tuser[0] && NO_WRAP, m_tdata[tdpc_pkg::OUT_COUNT_W-1:0] != '0, "prime not counted")
endmodule

bind trial_division_prime_counter_unit tdpc_checker #(.COUNT_WIDTH(COUNT_WIDTH)) u_tdpc_checker (.*);
